@@ hw/rtl/reach_segment_tree_argmin_argmax_top_assert.svh @@
// Assertion macros used by the checker file of this block.
`ifndef REACH_SEGMENT_TREE_ARGMIN_ARGMAX_TOP_ASSERT_SVH
`define REACH_SEGMENT_TREE_ARGMIN_ARGMAX_TOP_ASSERT_SVH

// Same-cycle implication, off while reset is held.
`define RSTAM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rstam check failed");

// Next-cycle implication, off while reset is held.
`define RSTAM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rstam check failed");

// Next-cycle implication that also runs through reset.
`define RSTAM_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("rstam check failed");

`endif

@@ hw/rtl/rstam_pkg.sv @@
package rstam_pkg;

  localparam int IDX_W   = 10;
  localparam int LEAVES  = 1 << IDX_W;
  localparam int NODE_W  = IDX_W + 1;
  localparam int NODES   = 2 * LEAVES;
  localparam int LKEY_W  = IDX_W + 2;
  localparam int RKEY_W  = IDX_W + 1;
  localparam int RANGE_W = 12;

  // Left key of an empty node: above any real position minus radius.
  localparam logic signed [LKEY_W-1:0] LKEY_SENTINEL = LKEY_W'(LEAVES);

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef logic [3:0] op_t;
  typedef logic [1:0] sel_t;
  typedef logic [2:0] cond_t;
  typedef logic [4:0] step_t;

  localparam op_t OP_NOP     = 4'd0;
  localparam op_t OP_RAD_WR  = 4'd1;
  localparam op_t OP_TREE_RD = 4'd2;
  localparam op_t OP_RAD_RD  = 4'd3;
  localparam op_t OP_WR_CMP  = 4'd4;
  localparam op_t OP_Q_INIT  = 4'd5;
  localparam op_t OP_Q_SEED  = 4'd6;
  localparam op_t OP_Q_CMP   = 4'd7;
  localparam op_t OP_ADV     = 4'd8;
  localparam op_t OP_FIN     = 4'd9;

  localparam sel_t SEL_NODE = 2'd0;
  localparam sel_t SEL_I    = 2'd1;
  localparam sel_t SEL_J    = 2'd2;

  localparam cond_t C_NEXT     = 3'd0;
  localparam cond_t C_ALWAYS   = 3'd1;
  localparam cond_t C_POS_ZERO = 3'd2;
  localparam cond_t C_NOT_ROOT = 3'd3;
  localparam cond_t C_EMPTY    = 3'd4;
  localparam cond_t C_I_GT_J   = 3'd5;
  localparam cond_t C_I_EVEN   = 3'd6;
  localparam cond_t C_J_ODD    = 3'd7;

  localparam step_t STEP_W_START = 5'd0;
  localparam step_t STEP_W_RD    = 5'd1;
  localparam step_t STEP_W_RR    = 5'd2;
  localparam step_t STEP_W_CMP   = 5'd3;
  localparam step_t STEP_W_END   = 5'd4;
  localparam step_t STEP_Q_START = 5'd5;
  localparam step_t STEP_Q_SEED  = 5'd6;
  localparam step_t STEP_Q_CHK   = 5'd7;
  localparam step_t STEP_Q_CHI   = 5'd8;
  localparam step_t STEP_Q_IRD   = 5'd9;
  localparam step_t STEP_Q_IRR   = 5'd10;
  localparam step_t STEP_Q_ICMP  = 5'd11;
  localparam step_t STEP_Q_CHJ   = 5'd12;
  localparam step_t STEP_Q_JRD   = 5'd13;
  localparam step_t STEP_Q_JRR   = 5'd14;
  localparam step_t STEP_Q_JCMP  = 5'd15;
  localparam step_t STEP_Q_ADV   = 5'd16;
  localparam step_t STEP_FIN     = 5'd17;

  typedef struct packed {
    op_t   op;
    sel_t  sel;
    cond_t cond;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic pos_zero;
    logic empty;
    logic not_root;
    logic i_gt_j;
    logic i_even;
    logic j_odd;
  } flags_t;

  function automatic ctrl_t cw(op_t op, sel_t sel, cond_t cond, step_t target);
    ctrl_t c;
    c.op     = op;
    c.sel    = sel;
    c.cond   = cond;
    c.target = target;
    return c;
  endfunction

  // Microprogram. Each tree visit is three steps: read both trees, read the
  // radii of the two indices found, then compare and update.
  function automatic ctrl_t ucode(step_t step);
    ctrl_t c;
    case (step)
      STEP_W_START: c = cw(OP_RAD_WR,  SEL_NODE, C_POS_ZERO, STEP_FIN);
      STEP_W_RD:    c = cw(OP_TREE_RD, SEL_NODE, C_NEXT,     STEP_FIN);
      STEP_W_RR:    c = cw(OP_RAD_RD,  SEL_NODE, C_NEXT,     STEP_FIN);
      STEP_W_CMP:   c = cw(OP_WR_CMP,  SEL_NODE, C_NOT_ROOT, STEP_W_RD);
      STEP_W_END:   c = cw(OP_NOP,     SEL_NODE, C_ALWAYS,   STEP_FIN);
      STEP_Q_START: c = cw(OP_Q_INIT,  SEL_NODE, C_EMPTY,    STEP_FIN);
      STEP_Q_SEED:  c = cw(OP_Q_SEED,  SEL_NODE, C_NEXT,     STEP_FIN);
      STEP_Q_CHK:   c = cw(OP_NOP,     SEL_NODE, C_I_GT_J,   STEP_FIN);
      STEP_Q_CHI:   c = cw(OP_NOP,     SEL_I,    C_I_EVEN,   STEP_Q_CHJ);
      STEP_Q_IRD:   c = cw(OP_TREE_RD, SEL_I,    C_NEXT,     STEP_FIN);
      STEP_Q_IRR:   c = cw(OP_RAD_RD,  SEL_I,    C_NEXT,     STEP_FIN);
      STEP_Q_ICMP:  c = cw(OP_Q_CMP,   SEL_I,    C_NEXT,     STEP_FIN);
      STEP_Q_CHJ:   c = cw(OP_NOP,     SEL_J,    C_J_ODD,    STEP_Q_ADV);
      STEP_Q_JRD:   c = cw(OP_TREE_RD, SEL_J,    C_NEXT,     STEP_FIN);
      STEP_Q_JRR:   c = cw(OP_RAD_RD,  SEL_J,    C_NEXT,     STEP_FIN);
      STEP_Q_JCMP:  c = cw(OP_Q_CMP,   SEL_J,    C_NEXT,     STEP_FIN);
      STEP_Q_ADV:   c = cw(OP_ADV,     SEL_NODE, C_ALWAYS,   STEP_Q_CHK);
      default:      c = cw(OP_FIN,     SEL_NODE, C_NEXT,     STEP_FIN);
    endcase
    return c;
  endfunction

endpackage

@@ hw/rtl/rstam_ram.sv @@
module rstam_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/rstam_seq.sv @@
module rstam_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  rstam_pkg::step_t    entry,
  input  logic                adv,
  input  rstam_pkg::flags_t   flags,
  output rstam_pkg::ctrl_t    ctrl
);

  rstam_pkg::step_t step_r, step_nxt;
  logic             taken;

  assign ctrl = rstam_pkg::ucode(step_r);

  always_comb begin
    case (ctrl.cond)
      rstam_pkg::C_NEXT:     taken = 1'b0;
      rstam_pkg::C_ALWAYS:   taken = 1'b1;
      rstam_pkg::C_POS_ZERO: taken = flags.pos_zero;
      rstam_pkg::C_NOT_ROOT: taken = flags.not_root;
      rstam_pkg::C_EMPTY:    taken = flags.empty;
      rstam_pkg::C_I_GT_J:   taken = flags.i_gt_j;
      rstam_pkg::C_I_EVEN:   taken = flags.i_even;
      rstam_pkg::C_J_ODD:    taken = flags.j_odd;
      default:               taken = 1'b0;
    endcase
  end

  always_comb begin
    step_nxt = step_r;
    if (load) begin
      step_nxt = entry;
    end else if (adv) begin
      step_nxt = taken ? ctrl.target : step_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= rstam_pkg::STEP_FIN;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

@@ hw/rtl/reach_segment_tree_argmin_argmax_top.sv @@
// Channel | Dir | Fields (lowest bit first)
// in_     | in  | tdata: position[9:0] radius[19:10] range_low[31:20] range_high[43:32]
//         |     | tuser: mode (0 write, 1 query)
// out_    | out | tdata: left_index[9:0] right_index[19:10]
// cfg_    | in  | data: used_count
// One item at a time, run by a microprogram over four simple dual-port RAMs
// (two trees, two copies of the radius store); every tree node visit is three steps.
// A write visits the 11 tree levels from its leaf up to the root (none for position 0).
// A query walks the tree up level by level from the two range edges, visiting
// the edge nodes that fall inside the range; an empty range skips the walk.
// After reset a clearing pass zeroes all four RAMs before the first word is taken.
// A finished result waits in the output register; the next word may enter.
module reach_segment_tree_argmin_argmax_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,  // position, radius, range_low, range_high, zero pad
  input  logic        in_tuser,  // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata, // left_index, right_index, zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [9:0]  cfg_data
);

  localparam int IW = rstam_pkg::IDX_W;
  localparam int NW = rstam_pkg::NODE_W;
  localparam int KW = rstam_pkg::LKEY_W;
  localparam int RW = rstam_pkg::RKEY_W;
  localparam int GW = rstam_pkg::RANGE_W;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;

  function automatic logic signed [KW-1:0] lkey(logic [IW-1:0] idx, logic [IW-1:0] rad);
    logic signed [KW-1:0] k;
    if (idx == '0) begin
      k = rstam_pkg::LKEY_SENTINEL;
    end else begin
      k = signed'({2'b00, idx}) - signed'({2'b00, rad});
    end
    return k;
  endfunction

  logic [1:0]             state_r, state_nxt;
  logic [NW-1:0]          clr_r, clr_nxt;
  logic [IW-1:0]          used_r, used_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [IW-1:0]          out_left_r, out_left_nxt;
  logic [IW-1:0]          out_right_r, out_right_nxt;

  logic                   mode_r, mode_nxt;
  logic [IW-1:0]          pos_r, pos_nxt;
  logic [IW-1:0]          rad_r, rad_nxt;
  logic [IW-1:0]          lo_r, lo_nxt;
  logic [IW-1:0]          hi_r, hi_nxt;
  logic                   empty_r, empty_nxt;
  logic [NW-1:0]          node_r, node_nxt;
  logic [NW-1:0]          i_r, i_nxt;
  logic [NW-1:0]          j_r, j_nxt;
  logic [IW-1:0]          la_r, la_nxt;
  logic [IW-1:0]          ra_r, ra_nxt;
  logic signed [KW-1:0]   lkey_la_r, lkey_la_nxt;
  logic [RW-1:0]          rkey_ra_r, rkey_ra_nxt;

  rstam_pkg::ctrl_t       ctrl;
  rstam_pkg::flags_t      flags;
  rstam_pkg::step_t       entry;
  logic                   accept, run, clearing, adv, finish;

  logic signed [GW-1:0]   lo_s, hi_s, used_s, lo_c, hi_c;
  logic [NW-1:0]          tree_raddr;
  logic [IW-1:0]          ltree_q, rtree_q, rad_a_q, rad_b_q;
  logic signed [KW-1:0]   lkey_t, lkey_p;
  logic [RW-1:0]          rkey_t, rkey_p;
  logic                   rad_we, ltree_we, rtree_we;

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_right_r, out_left_r};

  assign accept   = in_tvalid && in_tready;
  assign run      = (state_r == ST_RUN);
  assign clearing = (state_r == ST_CLEAR);
  assign finish   = run && (ctrl.op == rstam_pkg::OP_FIN) && (!out_valid_r || out_tready);
  assign adv      = run && (ctrl.op != rstam_pkg::OP_FIN);
  assign entry    = (in_tuser == rstam_pkg::MODE_QUERY) ? rstam_pkg::STEP_Q_START
                                                        : rstam_pkg::STEP_W_START;

  // Range clamp happens once, as the word is taken.
  assign lo_s   = signed'(in_tdata[31:20]);
  assign hi_s   = signed'(in_tdata[43:32]);
  assign used_s = signed'({2'b00, used_r});
  assign lo_c   = (lo_s < GW'(1)) ? GW'(1) : lo_s;
  assign hi_c   = (hi_s > used_s) ? used_s : hi_s;

  assign flags.pos_zero = (pos_r == '0);
  assign flags.empty    = empty_r;
  assign flags.not_root = (node_r != NW'(1));
  assign flags.i_gt_j   = (i_r > j_r);
  assign flags.i_even   = !i_r[0];
  assign flags.j_odd    = j_r[0];

  rstam_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (accept),
    .entry (entry),
    .adv   (adv),
    .flags (flags),
    .ctrl  (ctrl)
  );

  always_comb begin
    case (ctrl.sel)
      rstam_pkg::SEL_I: tree_raddr = i_r;
      rstam_pkg::SEL_J: tree_raddr = j_r;
      default:          tree_raddr = node_r;
    endcase
  end

  assign lkey_t = lkey(ltree_q, rad_a_q);
  assign lkey_p = lkey(pos_r, rad_r);
  assign rkey_t = {1'b0, rtree_q} + {1'b0, rad_b_q};
  assign rkey_p = {1'b0, pos_r} + {1'b0, rad_r};

  assign rad_we   = clearing || (run && ctrl.op == rstam_pkg::OP_RAD_WR && !flags.pos_zero);
  assign ltree_we = clearing || (run && ctrl.op == rstam_pkg::OP_WR_CMP && lkey_t > lkey_p);
  assign rtree_we = clearing || (run && ctrl.op == rstam_pkg::OP_WR_CMP && rkey_t < rkey_p);

  rstam_ram #(.WIDTH(IW), .DEPTH(rstam_pkg::LEAVES)) u_rad_a (
    .clk   (clk),
    .we    (rad_we),
    .waddr (clearing ? clr_r[IW-1:0] : pos_r),
    .wdata (clearing ? '0 : rad_r),
    .re    (run && (ctrl.op == rstam_pkg::OP_RAD_RD || ctrl.op == rstam_pkg::OP_Q_INIT)),
    .raddr ((ctrl.op == rstam_pkg::OP_Q_INIT) ? hi_r : ltree_q),
    .rdata (rad_a_q)
  );

  rstam_ram #(.WIDTH(IW), .DEPTH(rstam_pkg::LEAVES)) u_rad_b (
    .clk   (clk),
    .we    (rad_we),
    .waddr (clearing ? clr_r[IW-1:0] : pos_r),
    .wdata (clearing ? '0 : rad_r),
    .re    (run && ctrl.op == rstam_pkg::OP_RAD_RD),
    .raddr (rtree_q),
    .rdata (rad_b_q)
  );

  rstam_ram #(.WIDTH(IW), .DEPTH(rstam_pkg::NODES)) u_ltree (
    .clk   (clk),
    .we    (ltree_we),
    .waddr (clearing ? clr_r : node_r),
    .wdata (clearing ? '0 : pos_r),
    .re    (run && ctrl.op == rstam_pkg::OP_TREE_RD),
    .raddr (tree_raddr),
    .rdata (ltree_q)
  );

  rstam_ram #(.WIDTH(IW), .DEPTH(rstam_pkg::NODES)) u_rtree (
    .clk   (clk),
    .we    (rtree_we),
    .waddr (clearing ? clr_r : node_r),
    .wdata (clearing ? '0 : pos_r),
    .re    (run && ctrl.op == rstam_pkg::OP_TREE_RD),
    .raddr (tree_raddr),
    .rdata (rtree_q)
  );

  // Control: clearing pass, idle, microprogram run, result register.
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    used_nxt      = used_r;
    out_valid_nxt = out_valid_r;
    if (cfg_valid && cfg_ready) begin
      used_nxt = cfg_data;
    end
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + NW'(1);
        if (clr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (finish) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath registers.
  always_comb begin
    mode_nxt      = mode_r;
    pos_nxt       = pos_r;
    rad_nxt       = rad_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    empty_nxt     = empty_r;
    node_nxt      = node_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    la_nxt        = la_r;
    ra_nxt        = ra_r;
    lkey_la_nxt   = lkey_la_r;
    rkey_ra_nxt   = rkey_ra_r;
    out_left_nxt  = out_left_r;
    out_right_nxt = out_right_r;
    if (accept) begin
      mode_nxt  = in_tuser;
      pos_nxt   = in_tdata[9:0];
      rad_nxt   = in_tdata[19:10];
      lo_nxt    = lo_c[IW-1:0];
      hi_nxt    = hi_c[IW-1:0];
      empty_nxt = (lo_c > hi_c);
    end
    if (run) begin
      case (ctrl.op)
        rstam_pkg::OP_RAD_WR: node_nxt = {1'b1, pos_r};
        rstam_pkg::OP_WR_CMP: node_nxt = node_r >> 1;
        rstam_pkg::OP_Q_INIT: begin
          i_nxt       = {1'b1, lo_r};
          j_nxt       = {1'b1, hi_r};
          la_nxt      = empty_r ? '0 : hi_r;
          ra_nxt      = '0;
          rkey_ra_nxt = '0;
        end
        rstam_pkg::OP_Q_SEED: lkey_la_nxt = lkey(hi_r, rad_a_q);
        rstam_pkg::OP_Q_CMP: begin
          if (lkey_t < lkey_la_r) begin
            la_nxt      = ltree_q;
            lkey_la_nxt = lkey_t;
          end
          if (rkey_t > rkey_ra_r) begin
            ra_nxt      = rtree_q;
            rkey_ra_nxt = rkey_t;
          end
        end
        rstam_pkg::OP_ADV: begin
          // Left bound rounds up, right bound rounds down, one level higher.
          i_nxt = (i_r >> 1) + NW'(i_r[0]);
          j_nxt = (j_r >> 1) - NW'(!j_r[0]);
        end
        rstam_pkg::OP_FIN: begin
          if (finish) begin
            out_left_nxt  = (mode_r == rstam_pkg::MODE_QUERY) ? la_r : '0;
            out_right_nxt = (mode_r == rstam_pkg::MODE_QUERY) ? ra_r : '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      used_r      <= IW'(1022);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    pos_r       <= pos_nxt;
    rad_r       <= rad_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    empty_r     <= empty_nxt;
    node_r      <= node_nxt;
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    la_r        <= la_nxt;
    ra_r        <= ra_nxt;
    lkey_la_r   <= lkey_la_nxt;
    rkey_ra_r   <= rkey_ra_nxt;
    out_left_r  <= out_left_nxt;
    out_right_r <= out_right_nxt;
  end

endmodule

@@ hw/rtl/rstam_chk.sv @@
`include "reach_segment_tree_argmin_argmax_top_assert.svh"

module rstam_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // The clearing pass keeps the input closed right after reset.
  `RSTAM_ASSERT_NEXT_ALWAYS(a_closed_after_reset, clk, !rst_n, !in_tready)

  // Only one word is worked on at a time.
  `RSTAM_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_tvalid && in_tready, !in_tready)

  // A new result only appears at the end of a run, when the input was closed.
  `RSTAM_ASSERT_NOW(a_result_after_run, clk, rst_n, $rose(out_tvalid), $past(!in_tready))

  // A result that is not taken stays, unchanged.
  `RSTAM_ASSERT_NEXT(a_result_holds, clk, rst_n, out_tvalid && !out_tready,
                     out_tvalid && $stable(out_tdata))

endmodule

bind reach_segment_tree_argmin_argmax_top rstam_chk u_rstam_chk (.*);
